### src/sap_pkg.sv
// ----------------------------------------------------------------------------
// sap_pkg
// Shared types, codes and helpers for the subnet address pool.
// ----------------------------------------------------------------------------
package sap_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int unsigned HOST_BITS_DEF   = 8;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  // Fixed field widths of the request and response items.
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned HDL_W     = 16;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PREFIX_W  = 5;
  localparam int unsigned WORKER_W  = 8;

  // Host-bit count and the pool limit 2^h - 1 (h never exceeds 16).
  localparam int unsigned HCNT_W  = 6;
  localparam int unsigned LIMIT_W = 17;

  // Reset values of the configuration registers.
  localparam logic [ADDR_W-1:0]   BASE_RST   = '0;
  localparam logic [PREFIX_W-1:0] PREFIX_RST = 5'd24;
  localparam logic [WORKER_W-1:0] WORKER_RST = '0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUBNET_BASE = 2'd0,
    CFG_PREFIX_LEN  = 2'd1,
    CFG_WORKER_ID   = 2'd2
  } cfg_idx_e;

  // Operation codes; codes above rebuild are accepted and do nothing.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_BIND    = 3'd2,
    OP_LOOKUP  = 3'd3,
    OP_REBUILD = 3'd4
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_OUTSIDE     = 3'd2,
    ST_NOT_ALLOC   = 3'd3,
    ST_NOT_BOUND   = 3'd4
  } status_e;

  // Per-slot flag word: allocated in bit 0, bound in bit 1.
  localparam int unsigned FLAG_W         = 2;
  localparam int unsigned FLAG_ALLOC_BIT = 0;
  localparam int unsigned FLAG_BOUND_BIT = 1;
  localparam logic [FLAG_W-1:0] FLAGS_CLEAR = 2'b00;
  localparam logic [FLAG_W-1:0] FLAGS_ALLOC = 2'b01;
  localparam logic [FLAG_W-1:0] FLAGS_BOUND = 2'b11;

  // Low-byte values that are never handed out.
  localparam logic [7:0] LB_NET   = 8'h00;
  localparam logic [7:0] LB_GW    = 8'h01;
  localparam logic [7:0] LB_BCAST = 8'hFF;
  localparam logic [ADDR_W-1:0] SEQ_FIRST = 32'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted request item
    logic sweep_init;  // reset the queue pointers before a rebuild sweep
    logic sweep_step;  // clear one slot's flags and advance the sweep index
    logic fill_en;     // during a sweep, also push usable slots to the queue
    logic commit;      // apply the operation and load the response register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_rebuild;  // latched op is a rebuild
    logic sweep_last;  // sweep index is on the last slot
    logic out_free;    // response register can take a new item
  } sts_t;

  // True when a sequence number is one that a rebuild would produce.
  function automatic logic seq_usable(input logic [ADDR_W-1:0]  s,
                                      input logic [LIMIT_W-1:0] limit);
    return (s >= SEQ_FIRST) && (s < ADDR_W'(limit)) &&
           (s[7:0] != LB_NET) && (s[7:0] != LB_GW) && (s[7:0] != LB_BCAST);
  endfunction

endpackage

### src/sap_req_if.sv
// ----------------------------------------------------------------------------
// sap_req_if
// Request channel: valid/ready handshake carrying op, address and handle.
// ----------------------------------------------------------------------------
interface sap_req_if;
  logic                       valid;
  logic                       ready;
  logic [sap_pkg::OP_W-1:0]   op;
  logic [sap_pkg::ADDR_W-1:0] address;
  logic [sap_pkg::HDL_W-1:0]  handle;

  modport source (output valid, op, address, handle, input ready);
  modport sink   (input valid, op, address, handle, output ready);
endinterface

### src/sap_rsp_if.sv
// ----------------------------------------------------------------------------
// sap_rsp_if
// Response channel: valid/ready handshake carrying status, address and handle.
// ----------------------------------------------------------------------------
interface sap_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sap_pkg::STATUS_W-1:0] status;
  logic [sap_pkg::ADDR_W-1:0]   result_address;
  logic [sap_pkg::HDL_W-1:0]    result_handle;

  modport source (output valid, status, result_address, result_handle, input ready);
  modport sink   (input valid, status, result_address, result_handle, output ready);
endinterface

### src/sap_ram.sv
// ----------------------------------------------------------------------------
// sap_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read (read returns the old data on a collision).
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/sap_ctrl.sv
// ----------------------------------------------------------------------------
// sap_ctrl
// Sequencer: reset clearing pass, request read/commit steps, rebuild sweep.
// ----------------------------------------------------------------------------
module sap_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  sap_pkg::sts_t sts_i,
  output sap_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    READ,
    SWEEP,
    COMMIT
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      CLEAR: begin
        // Clear every slot's flags once after reset.
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = IDLE;
        end
      end
      IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = READ;
        end
      end
      READ: begin
        // Memory reads for the latched item are in flight this cycle.
        if (sts_i.is_rebuild) begin
          cmd_o.sweep_init = 1'b1;
          state_d          = SWEEP;
        end else begin
          state_d = COMMIT;
        end
      end
      SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        cmd_o.fill_en    = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = COMMIT;
        end
      end
      COMMIT: begin
        // Finish the item once the response register is free, and take the
        // next item in the same cycle.
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          req_ready_o  = 1'b1;
          if (req_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = READ;
          end else begin
            state_d = IDLE;
          end
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/sap_dp.sv
// ----------------------------------------------------------------------------
// sap_dp
// Datapath: configuration, address decode, free-list queue, slot flags,
// handle store and the response register.
// ----------------------------------------------------------------------------
module sap_dp #(
  parameter int unsigned HOST_BITS   = sap_pkg::HOST_BITS_DEF,
  parameter int unsigned HANDLE_BITS = sap_pkg::HANDLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sap_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sap_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic [sap_pkg::OP_W-1:0]         req_op_i,
  input  logic [sap_pkg::ADDR_W-1:0]       req_address_i,
  input  logic [sap_pkg::HDL_W-1:0]        req_handle_i,
  input  logic                             rsp_ready_i,
  output logic                             rsp_valid_o,
  output logic [sap_pkg::STATUS_W-1:0]     rsp_status_o,
  output logic [sap_pkg::ADDR_W-1:0]       rsp_address_o,
  output logic [sap_pkg::HDL_W-1:0]        rsp_handle_o,
  input  sap_pkg::cmd_t                    cmd_i,
  output sap_pkg::sts_t                    sts_o
);

  localparam int unsigned SLOTS = 1 << HOST_BITS;
  localparam logic [HOST_BITS-1:0] PTR_ONE = HOST_BITS'(1);
  localparam logic [HOST_BITS:0]   CNT_ONE = (HOST_BITS + 1)'(1);
  localparam logic [HOST_BITS:0]   CNT_ZERO = '0;

  // Configuration registers.
  logic [sap_pkg::ADDR_W-1:0]   base_q;
  logic [sap_pkg::PREFIX_W-1:0] prefix_q;
  logic [sap_pkg::WORKER_W-1:0] worker_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= sap_pkg::BASE_RST;
      prefix_q <= sap_pkg::PREFIX_RST;
      worker_q <= sap_pkg::WORKER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sap_pkg::CFG_SUBNET_BASE: base_q   <= cfg_wdata_i;
        sap_pkg::CFG_PREFIX_LEN:  prefix_q <= cfg_wdata_i[sap_pkg::PREFIX_W-1:0];
        sap_pkg::CFG_WORKER_ID:   worker_q <= cfg_wdata_i[sap_pkg::WORKER_W-1:0];
        default: ;
      endcase
    end
  end

  // Pool origin and sequence limit, derived from the configuration.
  logic [sap_pkg::HCNT_W-1:0]  hraw, hsel;
  logic [sap_pkg::ADDR_W-1:0]  low_mask, origin;
  logic [sap_pkg::LIMIT_W-1:0] limit;

  always_comb begin
    hraw     = sap_pkg::HCNT_W'(32) - sap_pkg::HCNT_W'(prefix_q);
    hsel     = (hraw > sap_pkg::HCNT_W'(HOST_BITS)) ? sap_pkg::HCNT_W'(HOST_BITS) : hraw;
    low_mask = (sap_pkg::ADDR_W'(1) << hsel) - sap_pkg::ADDR_W'(1);
    limit    = (sap_pkg::LIMIT_W'(1) << hsel) - sap_pkg::LIMIT_W'(1);
    origin   = (base_q & ~low_mask) + (sap_pkg::ADDR_W'(worker_q) << hsel);
  end

  // Latched request item.
  logic [sap_pkg::OP_W-1:0]   op_q;
  logic [sap_pkg::ADDR_W-1:0] addr_q;
  logic [sap_pkg::HDL_W-1:0]  hdl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= req_op_i;
      addr_q <= req_address_i;
      hdl_q  <= req_handle_i;
    end
  end

  // Address decode to a slot number.
  logic [sap_pkg::ADDR_W-1:0] dec_off;
  logic                       dec_ok;
  logic [HOST_BITS-1:0]       dec_seq;

  assign dec_off = addr_q - origin;
  assign dec_ok  = sap_pkg::seq_usable(dec_off, limit);
  assign dec_seq = dec_off[HOST_BITS-1:0];

  // Queue pointers, count and sweep index.
  logic [HOST_BITS-1:0] head_q, head_d, tail_q, tail_d, idx_q, idx_d;
  logic [HOST_BITS:0]   count_q, count_d;
  logic                 fill_ok;

  assign fill_ok = cmd_i.sweep_step && cmd_i.fill_en &&
                   sap_pkg::seq_usable(sap_pkg::ADDR_W'(idx_q), limit);

  // Memories.
  logic                          q_we, flg_we, hs_we;
  logic [HOST_BITS-1:0]          q_waddr, q_wdata, q_rdata, flg_waddr;
  logic [sap_pkg::FLAG_W-1:0]    flg_wdata, flg_rdata;
  logic [HANDLE_BITS-1:0]        hs_rdata;
  logic                          is_alloc, is_bound;

  assign is_alloc = flg_rdata[sap_pkg::FLAG_ALLOC_BIT];
  assign is_bound = flg_rdata[sap_pkg::FLAG_BOUND_BIT];

  sap_ram #(.WIDTH(HOST_BITS), .DEPTH(SLOTS)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  sap_ram #(.WIDTH(sap_pkg::FLAG_W), .DEPTH(SLOTS)) u_flags (
    .clk_i   (clk_i),
    .we_i    (flg_we),
    .waddr_i (flg_waddr),
    .wdata_i (flg_wdata),
    .raddr_i (dec_seq),
    .rdata_o (flg_rdata)
  );

  sap_ram #(.WIDTH(HANDLE_BITS), .DEPTH(SLOTS)) u_handles (
    .clk_i   (clk_i),
    .we_i    (hs_we),
    .waddr_i (dec_seq),
    .wdata_i (HANDLE_BITS'(hdl_q)),
    .raddr_i (dec_seq),
    .rdata_o (hs_rdata)
  );

  // Operation results and the state updates that go with them.
  logic [sap_pkg::STATUS_W-1:0] res_status;
  logic [sap_pkg::ADDR_W-1:0]   res_addr;
  logic [sap_pkg::HDL_W-1:0]    res_hdl;

  always_comb begin
    res_status = sap_pkg::ST_OK;
    res_addr   = addr_q;
    res_hdl    = '0;
    q_we       = 1'b0;
    q_waddr    = tail_q;
    q_wdata    = dec_seq;
    flg_we     = 1'b0;
    flg_waddr  = dec_seq;
    flg_wdata  = sap_pkg::FLAGS_CLEAR;
    hs_we      = 1'b0;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    idx_d      = idx_q;

    // Sweep: clear each slot and, during a rebuild, push the usable ones.
    if (cmd_i.sweep_init) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
      idx_d   = '0;
    end
    if (cmd_i.sweep_step) begin
      flg_we    = 1'b1;
      flg_waddr = idx_q;
      idx_d     = idx_q + PTR_ONE;
      if (fill_ok) begin
        q_we    = 1'b1;
        q_wdata = idx_q;
        tail_d  = tail_q + PTR_ONE;
        count_d = count_q + CNT_ONE;
      end
    end

    case (op_q)
      sap_pkg::OP_ALLOC: begin
        if (count_q == CNT_ZERO) begin
          res_status = sap_pkg::ST_EMPTY;
        end else begin
          res_addr = origin + sap_pkg::ADDR_W'(q_rdata);
          if (cmd_i.commit) begin
            flg_we    = 1'b1;
            flg_waddr = q_rdata;
            flg_wdata = sap_pkg::FLAGS_ALLOC;
            head_d    = head_q + PTR_ONE;
            count_d   = count_q - CNT_ONE;
          end
        end
      end
      sap_pkg::OP_FREE: begin
        if (!dec_ok) begin
          res_status = sap_pkg::ST_OUTSIDE;
        end else if (!is_alloc) begin
          res_status = sap_pkg::ST_NOT_ALLOC;
        end else if (cmd_i.commit) begin
          flg_we  = 1'b1;
          q_we    = 1'b1;
          tail_d  = tail_q + PTR_ONE;
          count_d = count_q + CNT_ONE;
        end
      end
      sap_pkg::OP_BIND: begin
        if (!dec_ok) begin
          res_status = sap_pkg::ST_OUTSIDE;
        end else if (!is_alloc) begin
          res_status = sap_pkg::ST_NOT_ALLOC;
        end else if (cmd_i.commit) begin
          flg_we    = 1'b1;
          flg_wdata = sap_pkg::FLAGS_BOUND;
          hs_we     = 1'b1;
        end
      end
      sap_pkg::OP_LOOKUP: begin
        if (!dec_ok) begin
          res_status = sap_pkg::ST_OUTSIDE;
        end else if (!is_alloc) begin
          res_status = sap_pkg::ST_NOT_ALLOC;
        end else if (!is_bound) begin
          res_status = sap_pkg::ST_NOT_BOUND;
        end else begin
          res_hdl = sap_pkg::HDL_W'(hs_rdata);
        end
      end
      sap_pkg::OP_REBUILD: begin
        if (count_q == CNT_ZERO) begin
          res_status = sap_pkg::ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  // Queue control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Response register.
  logic                         out_valid_q, out_valid_d;
  logic [sap_pkg::STATUS_W-1:0] out_status_q;
  logic [sap_pkg::ADDR_W-1:0]   out_addr_q;
  logic [sap_pkg::HDL_W-1:0]    out_hdl_q;

  assign out_valid_d = cmd_i.commit || (out_valid_q && !rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_addr_q   <= res_addr;
      out_hdl_q    <= res_hdl;
    end
  end

  assign rsp_valid_o   = out_valid_q;
  assign rsp_status_o  = out_status_q;
  assign rsp_address_o = out_addr_q;
  assign rsp_handle_o  = out_hdl_q;

  // Status to the controller.
  assign sts_o.is_rebuild = (op_q == sap_pkg::OP_REBUILD);
  assign sts_o.sweep_last = &idx_q;
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

endmodule

### src/subnet_address_pool.sv
// ----------------------------------------------------------------------------
// subnet_address_pool
// Pool of IPv4 host addresses on a FIFO free list, with session handles.
// ----------------------------------------------------------------------------
// Alloc, free, bind and lookup each pass through a READ step for the registered
// read of the free-list, slot-flag and handle memories and a COMMIT step that
// applies the update and loads the result into the output register; the next
// item is taken in the commit cycle, so a new item is accepted as the last one
// finishes while the result side keeps up. A rebuild sweeps every slot of the
// free list memory, one per cycle. After reset the block runs a clearing pass
// over the slot flags before it accepts the first item; configuration writes
// are taken at any time.
// ----------------------------------------------------------------------------
module subnet_address_pool #(
  parameter int unsigned HOST_BITS   = sap_pkg::HOST_BITS_DEF,
  parameter int unsigned HANDLE_BITS = sap_pkg::HANDLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sap_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sap_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  sap_req_if.sink                        req_i,
  sap_rsp_if.source                      rsp_o
);

  sap_pkg::cmd_t cmd;
  sap_pkg::sts_t sts;

  // Sequencer.
  sap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath with the pool memories.
  sap_dp #(
    .HOST_BITS   (HOST_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_op_i      (req_i.op),
    .req_address_i (req_i.address),
    .req_handle_i  (req_i.handle),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_status_o  (rsp_o.status),
    .rsp_address_o (rsp_o.result_address),
    .rsp_handle_o  (rsp_o.result_handle),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
